### rtl/tcc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_pkg: shared types and constants for the text console cursor engine
// Defines the command, result and configuration codes, the transaction
// structs, and the helpers that clamp the screen size and fix the cursor.
// ----------------------------------------------------------------------------
package tcc_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 128;
  localparam int TAB_STEP = 4;

  localparam int RES_DEPTH = 4;
  localparam int RES_PTR_W = 2;
  localparam int RES_CNT_W = 3;

  localparam logic [8:0]  COLS_RESET = 9'd128;
  localparam logic [7:0]  ROWS_RESET = 8'd48;
  localparam logic [23:0] BG_RESET   = 24'd0;

  localparam logic [7:0] CH_BS    = 8'h08;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    CMD_PUTC       = 2'd0,
    CMD_SET_CURSOR = 2'd1,
    CMD_CLEAR      = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    OP_DRAW   = 2'd0,
    OP_SCROLL = 2'd1,
    OP_FILL   = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    CFG_SCREEN_COLS = 2'd0,
    CFG_SCREEN_ROWS = 2'd1,
    CFG_DEFAULT_BG  = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  char_code;
    logic [23:0] fg_color;
    logic [23:0] bg_color;
    logic [7:0]  target_col;
    logic [6:0]  target_row;
  } item_t;

  // Row is one bit wider than a cell row: row == rows marks a pending wrap.
  typedef struct packed {
    logic [7:0] col;
    logic [7:0] row;
  } cursor_t;

  typedef struct packed {
    op_t         op;
    logic [7:0]  cell_col;
    logic [6:0]  cell_row;
    logic [7:0]  glyph;
    logic [23:0] ink_color;
    logic [23:0] paper_color;
    logic        last;
  } result_t;

  function automatic logic [8:0] eff_cols(input logic [8:0] raw);
    logic [8:0] val;
    if (raw == 9'd0) begin
      val = 9'd1;
    end else if (raw > 9'(MAX_COLS)) begin
      val = 9'(MAX_COLS);
    end else begin
      val = raw;
    end
    return val;
  endfunction

  function automatic logic [7:0] eff_rows(input logic [7:0] raw);
    logic [7:0] val;
    if (raw == 8'd0) begin
      val = 8'd1;
    end else if (raw > 8'(MAX_ROWS)) begin
      val = 8'(MAX_ROWS);
    end else begin
      val = raw;
    end
    return val;
  endfunction

  // Send a cursor that is neither on screen nor pending to the origin.
  function automatic cursor_t fix_cursor(input cursor_t cur, input logic [8:0] cols,
                                         input logic [7:0] rows);
    logic    on_screen;
    logic    pend;
    cursor_t res;
    on_screen = ({1'b0, cur.col} < cols) && (cur.row < rows);
    pend      = (cur.col == 8'd0) && (cur.row == rows);
    res       = cur;
    if (!on_screen && !pend) begin
      res = '0;
    end
    return res;
  endfunction

endpackage

### rtl/tcc_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_step: command decode and cursor update
// Turns one staged command and the current cursor into the next cursor and
// up to two result transactions (scroll, draw or fill).
// ----------------------------------------------------------------------------
module tcc_step (
  input  tcc_pkg::item_t   item,
  input  tcc_pkg::cursor_t cur,
  input  logic [8:0]       cols,
  input  logic [7:0]       rows,
  input  logic [23:0]      default_bg,
  output tcc_pkg::cursor_t cur_nxt,
  output tcc_pkg::result_t res0,
  output tcc_pkg::result_t res1,
  output logic [1:0]       res_cnt
);

  logic             pending;
  logic [7:0]       rows_m1;
  logic [8:0]       cols_m1;
  logic [8:0]       row_inc;
  logic [8:0]       tab_col;
  logic [8:0]       base_inc;
  tcc_pkg::cursor_t base;
  tcc_pkg::result_t scroll_res;
  tcc_pkg::result_t draw_res;
  logic [7:0]       bs_col;

  assign pending  = cur.row >= rows;
  assign rows_m1  = rows - 8'd1;
  assign cols_m1  = cols - 9'd1;
  assign row_inc  = {1'b0, cur.row} + 9'd1;
  assign tab_col  = {1'b0, cur.col} + 9'(tcc_pkg::TAB_STEP);
  // A pending wrap draws on the last row once the scroll has run.
  assign base     = pending ? tcc_pkg::cursor_t'{col: 8'd0, row: rows_m1} : cur;
  assign base_inc = {1'b0, base.col} + 9'd1;
  assign bs_col   = (cur.col == 8'd0) ? 8'd0 : cur.col - 8'd1;

  assign scroll_res = '{op: tcc_pkg::OP_SCROLL, cell_col: 8'd0, cell_row: rows_m1[6:0],
                        glyph: tcc_pkg::CH_SPACE, ink_color: 24'd0,
                        paper_color: item.bg_color, last: 1'b0};
  assign draw_res   = '{op: tcc_pkg::OP_DRAW, cell_col: base.col, cell_row: base.row[6:0],
                        glyph: item.char_code, ink_color: item.fg_color,
                        paper_color: item.bg_color, last: 1'b1};

  always_comb begin
    cur_nxt = cur;
    res0    = '0;
    res1    = '0;
    res_cnt = 2'd0;
    case (tcc_pkg::cmd_t'(item.cmd))
      tcc_pkg::CMD_SET_CURSOR: begin
        if (({1'b0, item.target_col} < cols) && ({1'b0, item.target_row} < rows)) begin
          cur_nxt = '{col: item.target_col, row: {1'b0, item.target_row}};
        end
      end
      tcc_pkg::CMD_CLEAR: begin
        res0    = '{op: tcc_pkg::OP_FILL, cell_col: 8'd0, cell_row: 7'd0,
                    glyph: tcc_pkg::CH_SPACE, ink_color: 24'd0,
                    paper_color: default_bg, last: 1'b1};
        res_cnt = 2'd1;
      end
      tcc_pkg::CMD_PUTC: begin
        case (item.char_code)
          tcc_pkg::CH_NL: begin
            if (pending || (row_inc >= {1'b0, rows})) begin
              res0      = scroll_res;
              res0.last = 1'b1;
              res_cnt   = 2'd1;
              cur_nxt   = '{col: 8'd0, row: rows_m1};
            end else begin
              cur_nxt = '{col: 8'd0, row: row_inc[7:0]};
            end
          end
          tcc_pkg::CH_BS: begin
            // Drop at the origin and while a wrap is pending.
            if (!pending && !((cur.col == 8'd0) && (cur.row == 8'd0))) begin
              res0        = '{op: tcc_pkg::OP_DRAW, cell_col: bs_col,
                              cell_row: cur.row[6:0], glyph: tcc_pkg::CH_SPACE,
                              ink_color: 24'd0, paper_color: item.bg_color, last: 1'b1};
              res_cnt     = 2'd1;
              cur_nxt.col = bs_col;
            end
          end
          tcc_pkg::CH_TAB: begin
            if (!pending) begin
              cur_nxt.col = (tab_col >= cols) ? cols_m1[7:0] : tab_col[7:0];
            end
          end
          default: begin
            if (pending) begin
              res0    = scroll_res;
              res1    = draw_res;
              res_cnt = 2'd2;
            end else begin
              res0    = draw_res;
              res_cnt = 2'd1;
            end
            if (base_inc >= cols) begin
              cur_nxt = '{col: 8'd0, row: base.row + 8'd1};
            end else begin
              cur_nxt = '{col: base_inc[7:0], row: base.row};
            end
          end
        endcase
      end
      default: begin
      end
    endcase
  end

endmodule

### rtl/tcc_result_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcc_result_fifo: result transaction queue
// Four-entry queue that takes up to two results per cycle and hands out one.
// ----------------------------------------------------------------------------
module tcc_result_fifo (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [1:0]                       push_cnt,
  input  tcc_pkg::result_t                 push0,
  input  tcc_pkg::result_t                 push1,
  input  logic                             pop,
  output logic [tcc_pkg::RES_CNT_W-1:0]    free_cnt,
  output logic                             head_valid,
  output tcc_pkg::result_t                 head
);

  tcc_pkg::result_t                  mem_r [tcc_pkg::RES_DEPTH];
  logic [tcc_pkg::RES_PTR_W-1:0]     wr_ptr_r, wr_ptr_nxt;
  logic [tcc_pkg::RES_PTR_W-1:0]     rd_ptr_r, rd_ptr_nxt;
  logic [tcc_pkg::RES_CNT_W-1:0]     count_r, count_nxt;
  logic [tcc_pkg::RES_PTR_W-1:0]     wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + tcc_pkg::RES_PTR_W'(1);
  assign wr_ptr_nxt = wr_ptr_r + tcc_pkg::RES_PTR_W'(push_cnt);
  assign rd_ptr_nxt = rd_ptr_r + tcc_pkg::RES_PTR_W'(pop);
  assign count_nxt  = count_r + tcc_pkg::RES_CNT_W'(push_cnt) - tcc_pkg::RES_CNT_W'(pop);
  assign free_cnt   = tcc_pkg::RES_CNT_W'(tcc_pkg::RES_DEPTH) - count_r;
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_cnt != 2'd0) begin
      mem_r[wr_ptr_r] <= push0;
    end
    if (push_cnt == 2'd2) begin
      mem_r[wr_ptr_p1] <= push1;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    tcc_pkg::RES_CNT_W'(push_cnt) <= free_cnt)
    else $error("result queue overflow");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_valid)
    else $error("result queue underflow");

  a_count_matches_ptrs: assert property (@(posedge clk) disable iff (!rst_n)
    (count_r == tcc_pkg::RES_CNT_W'(tcc_pkg::RES_DEPTH)) ||
    (count_r[tcc_pkg::RES_PTR_W-1:0] == wr_ptr_r - rd_ptr_r))
    else $error("result queue count out of step with pointers");

endmodule

### rtl/text_console_cursor_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine: character-cell console cursor controller
// Keeps the cursor of a text console and turns put-char, set-cursor and
// clear-screen commands into draw, scroll and fill transactions.
// ----------------------------------------------------------------------------
// Throughput is one command per cycle while the result queue has room. A
// command is captured in the input register, then decoded and applied to the
// cursor once the queue has room for all its results, and its results land
// in a four-entry result queue whose head drives the result channel. Each
// command yields zero, one or two results (a printable character after a
// wrap past the bottom row yields a scroll and then a draw), and the result
// channel hands out one per cycle while out_stall is low, so a stream of
// such characters cannot run at one per cycle. The input register holds its
// command while the queue lacks room for its results.
// Write the configuration registers only while no command is in flight.
// ----------------------------------------------------------------------------
module text_console_cursor_engine (
  input  logic        clk,
  input  logic        rst_n,
  // configuration write port
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata,
  // command channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [7:0]  in_char_code,
  input  logic [23:0] in_fg_color,
  input  logic [23:0] in_bg_color,
  input  logic [7:0]  in_target_col,
  input  logic [6:0]  in_target_row,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_op,
  output logic [7:0]  out_cell_col,
  output logic [6:0]  out_cell_row,
  output logic [7:0]  out_glyph,
  output logic [23:0] out_ink_color,
  output logic [23:0] out_paper_color,
  output logic        out_last
);

  // configuration registers (raw values; the size is clamped on use)
  logic [8:0]  cols_r, cols_nxt;
  logic [7:0]  rows_r, rows_nxt;
  logic [23:0] bg_r, bg_nxt;
  logic [8:0]  cols_eff, cols_eff_new;
  logic [7:0]  rows_eff, rows_eff_new;
  logic        size_wr;

  // input stage
  logic             stage_valid_r, stage_valid_nxt;
  tcc_pkg::item_t   stage_r;
  logic             in_accept;
  logic             fire;

  // cursor and step results
  tcc_pkg::cursor_t cursor_r, cursor_nxt;
  tcc_pkg::cursor_t step_cur;
  tcc_pkg::result_t step_res0, step_res1;
  logic [1:0]       step_cnt;

  // result queue
  logic [tcc_pkg::RES_CNT_W-1:0] free_cnt;
  logic                          head_valid;
  tcc_pkg::result_t              head;
  logic [1:0]                    push_cnt;
  logic                          pop;

  assign cols_eff = tcc_pkg::eff_cols(cols_r);
  assign rows_eff = tcc_pkg::eff_rows(rows_r);

  // Configuration writes: a size change may leave the cursor off screen.
  assign size_wr = cfg_wr_en && ((cfg_index == tcc_pkg::CFG_SCREEN_COLS) ||
                                 (cfg_index == tcc_pkg::CFG_SCREEN_ROWS));

  always_comb begin
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    bg_nxt   = bg_r;
    if (cfg_wr_en) begin
      case (tcc_pkg::cfg_idx_t'(cfg_index))
        tcc_pkg::CFG_SCREEN_COLS: cols_nxt = cfg_wdata[8:0];
        tcc_pkg::CFG_SCREEN_ROWS: rows_nxt = cfg_wdata[7:0];
        tcc_pkg::CFG_DEFAULT_BG:  bg_nxt   = cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  assign cols_eff_new = tcc_pkg::eff_cols(cols_nxt);
  assign rows_eff_new = tcc_pkg::eff_rows(rows_nxt);

  // Fire the staged command once the queue has room for all its results.
  assign fire      = stage_valid_r &&
                     (tcc_pkg::RES_CNT_W'(step_cnt) <= free_cnt);
  assign in_stall  = stage_valid_r && !fire;
  assign in_accept = in_valid && !in_stall;

  // Refill the stage whenever it empties or moves on; otherwise hold.
  assign stage_valid_nxt = in_stall ? 1'b1 : in_valid;

  tcc_step u_step (
    .item       (stage_r),
    .cur        (cursor_r),
    .cols       (cols_eff),
    .rows       (rows_eff),
    .default_bg (bg_r),
    .cur_nxt    (step_cur),
    .res0       (step_res0),
    .res1       (step_res1),
    .res_cnt    (step_cnt)
  );

  always_comb begin
    cursor_nxt = cursor_r;
    if (fire) begin
      cursor_nxt = step_cur;
    end
    if (size_wr) begin
      cursor_nxt = tcc_pkg::fix_cursor(cursor_r, cols_eff_new, rows_eff_new);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r        <= tcc_pkg::COLS_RESET;
      rows_r        <= tcc_pkg::ROWS_RESET;
      bg_r          <= tcc_pkg::BG_RESET;
      cursor_r      <= '0;
      stage_valid_r <= 1'b0;
    end else begin
      cols_r        <= cols_nxt;
      rows_r        <= rows_nxt;
      bg_r          <= bg_nxt;
      cursor_r      <= cursor_nxt;
      stage_valid_r <= stage_valid_nxt;
    end
  end

  // Capture the command payload on accept; hold it while stalled.
  always_ff @(posedge clk) begin
    if (in_accept) begin
      stage_r <= '{cmd: in_cmd, char_code: in_char_code, fg_color: in_fg_color,
                   bg_color: in_bg_color, target_col: in_target_col,
                   target_row: in_target_row};
    end
  end

  assign push_cnt = fire ? step_cnt : 2'd0;
  assign pop      = head_valid && !out_stall;

  tcc_result_fifo u_result_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_cnt   (push_cnt),
    .push0      (step_res0),
    .push1      (step_res1),
    .pop        (pop),
    .free_cnt   (free_cnt),
    .head_valid (head_valid),
    .head       (head)
  );

  assign out_valid       = head_valid;
  assign out_op          = head.op;
  assign out_cell_col    = head.cell_col;
  assign out_cell_row    = head.cell_row;
  assign out_glyph       = head.glyph;
  assign out_ink_color   = head.ink_color;
  assign out_paper_color = head.paper_color;
  assign out_last        = head.last;

  // The cursor is on screen, or parked at column 0 one row below the bottom.
  a_cursor_legal: assert property (@(posedge clk) disable iff (!rst_n)
    ({1'b0, cursor_r.col} < cols_eff) &&
    ((cursor_r.row < rows_eff) || ((cursor_r.row == rows_eff) && (cursor_r.col == 8'd0))))
    else $error("cursor outside screen and not pending");

  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stage_valid_r)
    else $error("input stalled with empty stage");

  a_accept_loads_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> stage_valid_r)
    else $error("accepted command lost from stage");

endmodule

### tb/sv/text_console_cursor_engine_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cursor_engine_tb: self-checking bench for the console cursor engine
// Drives put-char, set-cursor and clear-screen transactions in bursts against a
// stalling result sink, predicts every draw, scroll and fill in a scoreboard
// and checks each result field by field across several screen geometries.
// ----------------------------------------------------------------------------
module text_console_cursor_engine_tb;

  // Cycles to let a command with no result drain out of the pipeline.
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 200000;
  localparam int REPORT_MAX    = 10;
  localparam int PHASE_ITEMS   = 130;
  // Index 3 is not a register; a write there must change nothing.
  localparam logic [1:0] CFG_UNUSED_IDX = 2'd3;
  localparam logic [1:0] CMD_UNUSED     = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [23:0] cfg_wdata = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [1:0]  in_cmd = '0;
  logic [7:0]  in_char_code = '0;
  logic [23:0] in_fg_color = '0;
  logic [23:0] in_bg_color = '0;
  logic [7:0]  in_target_col = '0;
  logic [6:0]  in_target_row = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [1:0]  out_op;
  logic [7:0]  out_cell_col;
  logic [6:0]  out_cell_row;
  logic [7:0]  out_glyph;
  logic [23:0] out_ink_color;
  logic [23:0] out_paper_color;
  logic        out_last;

  text_console_cursor_engine dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_wr_en       (cfg_wr_en),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_cmd          (in_cmd),
    .in_char_code    (in_char_code),
    .in_fg_color     (in_fg_color),
    .in_bg_color     (in_bg_color),
    .in_target_col   (in_target_col),
    .in_target_row   (in_target_row),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_op          (out_op),
    .out_cell_col    (out_cell_col),
    .out_cell_row    (out_cell_row),
    .out_glyph       (out_glyph),
    .out_ink_color   (out_ink_color),
    .out_paper_color (out_paper_color),
    .out_last        (out_last)
  );

  always #2 clk = ~clk;

  // --------------------------------------------------------------------------
  // Console shadow: registers and cursor as the bench believes them to be.
  // --------------------------------------------------------------------------
  logic [8:0]  cols_reg = tcc_pkg::COLS_RESET;
  logic [7:0]  rows_reg = tcc_pkg::ROWS_RESET;
  logic [23:0] fill_bg  = tcc_pkg::BG_RESET;
  int unsigned cur_col  = 0;
  int unsigned cur_row  = 0;

  // Draw, scroll and fill transactions still owed by the block, oldest first.
  tcc_pkg::result_t screen_ops_q[$];

  int fail_count  = 0;
  int burst_left  = 0;
  int cycle_count = 0;

  function automatic int unsigned live_cols();
    if (cols_reg == 9'd0) return 1;
    if (cols_reg > 9'(tcc_pkg::MAX_COLS)) return tcc_pkg::MAX_COLS;
    return cols_reg;
  endfunction

  function automatic int unsigned live_rows();
    if (rows_reg == 8'd0) return 1;
    if (rows_reg > 8'(tcc_pkg::MAX_ROWS)) return tcc_pkg::MAX_ROWS;
    return rows_reg;
  endfunction

  function automatic logic [23:0] rand24();
    return 24'($urandom);
  endfunction

  function automatic tcc_pkg::result_t make_op(tcc_pkg::op_t op, int unsigned col,
                                               int unsigned row, logic [7:0] glyph,
                                               logic [23:0] ink, logic [23:0] paper);
    tcc_pkg::result_t r;
    r.op          = op;
    r.cell_col    = col[7:0];
    r.cell_row    = row[6:0];
    r.glyph       = glyph;
    r.ink_color   = ink;
    r.paper_color = paper;
    r.last        = 1'b0;
    return r;
  endfunction

  // After a size change, send a cursor that fell off the screen home, unless
  // it is parked in the pending-wrap spot just below the last row.
  function automatic void park_lost_cursor();
    bit on_screen;
    bit parked;
    on_screen = (cur_col < live_cols()) && (cur_row < live_rows());
    parked    = (cur_col == 0) && (cur_row == live_rows());
    if (!on_screen && !parked) begin
      cur_col = 0;
      cur_row = 0;
    end
  endfunction

  function automatic void apply_reg_write(logic [1:0] idx, logic [23:0] data);
    case (idx)
      tcc_pkg::CFG_SCREEN_COLS: begin
        cols_reg = data[8:0];
        park_lost_cursor();
      end
      tcc_pkg::CFG_SCREEN_ROWS: begin
        rows_reg = data[7:0];
        park_lost_cursor();
      end
      tcc_pkg::CFG_DEFAULT_BG: begin
        fill_bg = data;
      end
      default: ;
    endcase
  endfunction

  // Advance the shadow cursor by one command and queue the screen operations
  // it produces; the final one of the command carries last.
  function automatic void apply_console_cmd(tcc_pkg::item_t it);
    tcc_pkg::result_t ops[2];
    int               n;
    int unsigned      cols;
    int unsigned      rows;
    bit               pend;
    n    = 0;
    cols = live_cols();
    rows = live_rows();
    pend = (cur_row >= rows);
    case (it.cmd)
      tcc_pkg::CMD_SET_CURSOR: begin
        if (it.target_col < cols && it.target_row < rows) begin
          cur_col = it.target_col;
          cur_row = it.target_row;
        end
      end
      tcc_pkg::CMD_CLEAR: begin
        ops[0] = make_op(tcc_pkg::OP_FILL, 0, 0, tcc_pkg::CH_SPACE, 24'd0, fill_bg);
        n = 1;
      end
      tcc_pkg::CMD_PUTC: begin
        if (it.char_code == tcc_pkg::CH_NL) begin
          if (pend || cur_row + 1 >= rows) begin
            ops[0] = make_op(tcc_pkg::OP_SCROLL, 0, rows - 1, tcc_pkg::CH_SPACE, 24'd0,
                             it.bg_color);
            n = 1;
            cur_col = 0;
            cur_row = rows - 1;
          end else begin
            cur_col = 0;
            cur_row = cur_row + 1;
          end
        end else if (it.char_code == tcc_pkg::CH_BS) begin
          if (!pend && !(cur_col == 0 && cur_row == 0)) begin
            if (cur_col != 0) cur_col = cur_col - 1;
            ops[0] = make_op(tcc_pkg::OP_DRAW, cur_col, cur_row, tcc_pkg::CH_SPACE, 24'd0,
                             it.bg_color);
            n = 1;
          end
        end else if (it.char_code == tcc_pkg::CH_TAB) begin
          if (!pend) begin
            if (cur_col + tcc_pkg::TAB_STEP >= cols) cur_col = cols - 1;
            else cur_col = cur_col + tcc_pkg::TAB_STEP;
          end
        end else begin
          if (pend) begin
            ops[0] = make_op(tcc_pkg::OP_SCROLL, 0, rows - 1, tcc_pkg::CH_SPACE, 24'd0,
                             it.bg_color);
            n = 1;
            cur_col = 0;
            cur_row = rows - 1;
          end
          ops[n] = make_op(tcc_pkg::OP_DRAW, cur_col, cur_row, it.char_code, it.fg_color,
                           it.bg_color);
          n = n + 1;
          cur_col = cur_col + 1;
          if (cur_col >= cols) begin
            cur_col = 0;
            cur_row = cur_row + 1;
          end
        end
      end
      default: ;
    endcase
    if (n > 0) ops[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) screen_ops_q.push_back(ops[i]);
  endfunction

  // --------------------------------------------------------------------------
  // Command driver: bursts of back-to-back transactions with random gaps.
  // --------------------------------------------------------------------------
  task automatic send_cmd(tcc_pkg::item_t it);
    int gap;
    if (burst_left == 0) begin
      // Mostly short bursts, sometimes long unbroken stretches.
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 150)
                                               : $urandom_range(1, 12);
      if ($urandom_range(0, 4) != 0) begin
        gap = $urandom_range(1, 6);
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left    = burst_left - 1;
    in_valid      <= 1'b1;
    in_cmd        <= it.cmd;
    in_char_code  <= it.char_code;
    in_fg_color   <= it.fg_color;
    in_bg_color   <= it.bg_color;
    in_target_col <= it.target_col;
    in_target_row <= it.target_row;
    // Hold the payload until the block takes it.
    do @(posedge clk); while (in_stall);
    apply_console_cmd(it);
  endtask

  task automatic send_fields(logic [1:0] cmd, logic [7:0] ch, logic [23:0] fg,
                             logic [23:0] bg, logic [7:0] tc, logic [6:0] tr);
    tcc_pkg::item_t it;
    it.cmd        = cmd;
    it.char_code  = ch;
    it.fg_color   = fg;
    it.bg_color   = bg;
    it.target_col = tc;
    it.target_row = tr;
    send_cmd(it);
  endtask

  // Drop valid, let every owed result come out, then let the pipe settle.
  task automatic wait_for_idle();
    in_valid   <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (screen_ops_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [23:0] data);
    wait_for_idle();
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    apply_reg_write(idx, data);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
  endtask

  // Random command: mostly printable text with control characters, cursor
  // moves and clears mixed in, plus a little of the unused code.
  function automatic tcc_pkg::item_t random_cmd();
    tcc_pkg::item_t it;
    int             pick;
    it.cmd        = tcc_pkg::CMD_PUTC;
    it.char_code  = 8'($urandom);
    it.fg_color   = rand24();
    it.bg_color   = rand24();
    it.target_col = 8'($urandom);
    it.target_row = 7'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 60) begin
      it.cmd = tcc_pkg::CMD_PUTC;
    end else if (pick < 70) begin
      it.char_code = tcc_pkg::CH_NL;
    end else if (pick < 78) begin
      it.char_code = tcc_pkg::CH_BS;
    end else if (pick < 85) begin
      it.char_code = tcc_pkg::CH_TAB;
    end else if (pick < 94) begin
      it.cmd = tcc_pkg::CMD_SET_CURSOR;
      if ($urandom_range(0, 9) < 7) begin
        it.target_col = 8'($urandom_range(0, live_cols() - 1));
        it.target_row = 7'($urandom_range(0, live_rows() - 1));
      end
    end else if (pick < 98) begin
      it.cmd = tcc_pkg::CMD_CLEAR;
    end else begin
      it.cmd = CMD_UNUSED;
    end
    return it;
  endfunction

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Fill a 2x2 screen, wrap past the bottom, then draw: scroll before draw.
  task automatic test_wrap_and_scroll();
    write_reg(tcc_pkg::CFG_SCREEN_COLS, 24'd2);
    write_reg(tcc_pkg::CFG_SCREEN_ROWS, 24'd2);
    send_fields(tcc_pkg::CMD_PUTC, 8'h00, 24'h000000, 24'h000000, 8'h00, 7'h00);
    send_fields(tcc_pkg::CMD_PUTC, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 7'h7F);
    send_fields(tcc_pkg::CMD_PUTC, 8'h41, rand24(), rand24(), 8'h00, 7'h00);
    send_fields(tcc_pkg::CMD_PUTC, 8'h42, rand24(), rand24(), 8'h00, 7'h00);
    send_fields(tcc_pkg::CMD_PUTC, 8'h5A, rand24(), rand24(), 8'h00, 7'h00);
  endtask

  // Tab clamp, backspace in all its forms, newline mid-screen, on the last
  // row and while a wrap is pending.
  task automatic test_control_chars();
    send_fields(tcc_pkg::CMD_PUTC, tcc_pkg::CH_TAB, rand24(), rand24(), 8'h00, 7'h00);
    send_fields(tcc_pkg::CMD_PUTC, tcc_pkg::CH_BS, rand24(), rand24(), 8'h00, 7'h00);
    send_fields(tcc_pkg::CMD_PUTC, tcc_pkg::CH_NL, rand24(), rand24(), 8'h00, 7'h00);
    send_fields(tcc_pkg::CMD_PUTC, tcc_pkg::CH_BS, rand24(), rand24(), 8'h00, 7'h00);
    send_fields(tcc_pkg::CMD_SET_CURSOR, 8'h00, rand24(), rand24(), 8'd0, 7'd0);
    send_fields(tcc_pkg::CMD_PUTC, tcc_pkg::CH_BS, rand24(), rand24(), 8'h00, 7'h00);
    send_fields(tcc_pkg::CMD_PUTC, tcc_pkg::CH_NL, rand24(), rand24(), 8'h00, 7'h00);
    send_fields(tcc_pkg::CMD_SET_CURSOR, 8'h00, rand24(), rand24(), 8'd1, 7'd1);
    send_fields(tcc_pkg::CMD_PUTC, 8'h7E, rand24(), rand24(), 8'h00, 7'h00);
    send_fields(tcc_pkg::CMD_PUTC, tcc_pkg::CH_BS, rand24(), rand24(), 8'h00, 7'h00);
    send_fields(tcc_pkg::CMD_PUTC, tcc_pkg::CH_TAB, rand24(), rand24(), 8'h00, 7'h00);
    send_fields(tcc_pkg::CMD_PUTC, tcc_pkg::CH_NL, rand24(), rand24(), 8'h00, 7'h00);
  endtask

  // Off-screen targets must leave the cursor alone.
  task automatic test_set_cursor();
    send_fields(tcc_pkg::CMD_SET_CURSOR, 8'h00, rand24(), rand24(), 8'hFF, 7'h7F);
    send_fields(tcc_pkg::CMD_SET_CURSOR, 8'h00, rand24(), rand24(), 8'd2, 7'd0);
    send_fields(tcc_pkg::CMD_SET_CURSOR, 8'h00, rand24(), rand24(), 8'd0, 7'd2);
  endtask

  task automatic test_clear_and_unused();
    write_reg(tcc_pkg::CFG_DEFAULT_BG, 24'hFFFFFF);
    send_fields(tcc_pkg::CMD_CLEAR, 8'h00, rand24(), rand24(), 8'h00, 7'h00);
    send_fields(CMD_UNUSED, 8'hFF, 24'hFFFFFF, 24'hFFFFFF, 8'hFF, 7'h7F);
  endtask

  // Clamped sizes, the corner cell of the largest screen, a cursor kept in
  // the pending spot and one thrown home by a size change.
  task automatic test_screen_size();
    write_reg(tcc_pkg::CFG_SCREEN_COLS, {15'h7FFF, 9'd511});
    write_reg(tcc_pkg::CFG_SCREEN_ROWS, {16'hFFFF, 8'd255});
    send_fields(tcc_pkg::CMD_SET_CURSOR, 8'h00, rand24(), rand24(), 8'hFF, 7'h7F);
    send_fields(tcc_pkg::CMD_PUTC, 8'h80, rand24(), rand24(), 8'h00, 7'h00);
    write_reg(tcc_pkg::CFG_SCREEN_COLS, 24'd0);
    write_reg(tcc_pkg::CFG_SCREEN_ROWS, 24'd0);
    write_reg(CFG_UNUSED_IDX, rand24());
    write_reg(tcc_pkg::CFG_DEFAULT_BG, 24'h000000);
  endtask

  // Random traffic over a spread of geometries, tiny screens among them so
  // that wraps and scrolls are frequent.
  task automatic test_random_traffic();
    int unsigned col_set[10];
    int unsigned row_set[10];
    int unsigned c;
    int unsigned r;
    col_set = '{1, 256, 2, 80, 511, 0, 5, 0, 0, 40};
    row_set = '{1, 128, 2, 25, 255, 0, 3, 0, 0, 1};
    for (int phase = 0; phase < 10; phase++) begin
      c = col_set[phase];
      r = row_set[phase];
      if (phase == 7 || phase == 8) begin
        c = $urandom_range(0, 511);
        r = $urandom_range(0, 255);
      end
      write_reg(tcc_pkg::CFG_SCREEN_COLS, {15'($urandom), 9'(c)});
      write_reg(tcc_pkg::CFG_SCREEN_ROWS, {16'($urandom), 8'(r)});
      write_reg(tcc_pkg::CFG_DEFAULT_BG, rand24());
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        // Hold off mid-phase until every owed result has come out.
        if (phase == 4 && i == PHASE_ITEMS / 2) wait_for_idle();
        send_cmd(random_cmd());
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Result sink: stall on a pattern that is picked anew at random.
  // --------------------------------------------------------------------------
  int stall_mode  = 0;
  int stall_hold  = 0;
  int stall_phase = 0;

  always @(posedge clk) begin
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 4);
      stall_hold = $urandom_range(40, 300);
    end else begin
      stall_hold = stall_hold - 1;
    end
    stall_phase = stall_phase + 1;
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      3:       out_stall <= ((stall_phase % 7) < 3);
      default: out_stall <= ((stall_phase % 24) < 14);
    endcase
  end

  // Compare each accepted result with the oldest owed operation.
  always @(posedge clk) begin : check_results
    tcc_pkg::result_t got;
    tcc_pkg::result_t want;
    if (rst_n && out_valid && !out_stall) begin
      got.op          = tcc_pkg::op_t'(out_op);
      got.cell_col    = out_cell_col;
      got.cell_row    = out_cell_row;
      got.glyph       = out_glyph;
      got.ink_color   = out_ink_color;
      got.paper_color = out_paper_color;
      got.last        = out_last;
      if (screen_ops_q.size() == 0) begin
        fail_count = fail_count + 1;
        if (fail_count <= REPORT_MAX)
          $display("tb: unexpected result op=%0d col=%0d row=%0d glyph=%02h", got.op,
                   got.cell_col, got.cell_row, got.glyph);
      end else begin
        want = screen_ops_q.pop_front();
        if (got.op !== want.op || got.cell_col !== want.cell_col ||
            got.cell_row !== want.cell_row || got.glyph !== want.glyph ||
            got.ink_color !== want.ink_color || got.paper_color !== want.paper_color ||
            got.last !== want.last) begin
          fail_count = fail_count + 1;
          if (fail_count <= REPORT_MAX) begin
            $display("tb: exp op=%0d col=%0d row=%0d glyph=%02h ink=%06h paper=%06h last=%0b",
                     want.op, want.cell_col, want.cell_row, want.glyph, want.ink_color,
                     want.paper_color, want.last);
            $display("tb: got op=%0d col=%0d row=%0d glyph=%02h ink=%06h paper=%06h last=%0b",
                     got.op, got.cell_col, got.cell_row, got.glyph, got.ink_color,
                     got.paper_color, got.last);
          end
        end
      end
    end
  end

  // Watchdog: end a hung run.
  always @(posedge clk) begin
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("[text_console_cursor_engine] ERROR");
      $finish;
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_wrap_and_scroll();
    test_control_chars();
    test_set_cursor();
    test_clear_and_unused();
    test_screen_size();
    test_random_traffic();
    // Drain the last results and give the block time to show any extras.
    wait_for_idle();
    if (fail_count == 0 && screen_ops_q.size() == 0) begin
      $display("[text_console_cursor_engine] OK");
    end else begin
      $display("[text_console_cursor_engine] ERROR");
    end
    $finish;
  end

endmodule
